/* src/cfs_pkg.sv */
// Shared types and constants for the command frame scanner.
// No dependencies; every other file imports this package.
`default_nettype none

package cfs_pkg;

  // Frame framing bytes and command codes.
  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;
  localparam logic [7:0] OP_GAIN   = 8'h10;
  localparam logic [7:0] OP_ARM    = 8'h40;
  localparam logic [7:0] OP_DISARM = 8'h41;

  // Window of earlier bytes and the fill levels each frame type needs.
  localparam int         WIN_DEPTH = 16;
  localparam int         CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam logic [CNT_W-1:0] GAIN_NEED = CNT_W'(WIN_DEPTH);
  localparam logic [CNT_W-1:0] ARM_NEED  = CNT_W'(3);
  localparam logic [CNT_W-1:0] WIN_FULL  = CNT_W'(WIN_DEPTH);

  // Event kinds as reported on the output word.
  localparam logic [1:0] EVT_GAIN   = 2'd0;
  localparam logic [1:0] EVT_ARM    = 2'd1;
  localparam logic [1:0] EVT_DISARM = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_EN  = 1'd1;

  // Input word: one received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_start;
  } frame_in_t;

  // Output word: one event.
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  loop_index;
    logic [31:0] gain_p_bits;
    logic [31:0] gain_i_bits;
    logic [31:0] gain_d_bits;
    logic        last_event;
  } event_out_t;

  // Everything one byte produced: up to one gain event and one arm/disarm event.
  typedef struct packed {
    logic        gain_hit;
    logic        arm_hit;
    logic [1:0]  arm_kind;
    logic [7:0]  loop_index;
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
  } hit_rec_t;

endpackage

`default_nettype wire

/* src/command_frame_scanner.sv */
// Command frame scanner: one received byte per word in, one event per word out.
// Path: a closing byte passes the scanner's input register and is then written into
// the queue, from whose head its event is offered.
// Throughput: one byte per cycle while the queue has room; a byte closing both a gain
// and an arm frame gives two words, and the queue depth sets how long bytes flow on.
// Reset (rst, synchronous): clears the window fill level, the queue and both enables.
// Depends on cfs_pkg, cfs_scanner and cfs_event_queue.
`default_nettype none

module command_frame_scanner
  import cfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data,
  input  wire logic                 rx_valid,
  output logic                      rx_stall,
  input  wire frame_in_t            rx_data,
  output logic                      evt_valid,
  input  wire logic                 evt_stall,
  output event_out_t                evt_data
);

  logic     gain_handler_enabled;
  logic     arm_handler_enabled;
  logic     rx_accept;
  logic     scan_busy;
  logic     scan_push;
  hit_rec_t scan_rec;
  logic     queue_full;

  // Configuration registers. Only bit 0 of the written value is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_handler_enabled <= 1'b0;
      arm_handler_enabled  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_EN: gain_handler_enabled <= cfg_data;
        CFG_ARM_EN:  arm_handler_enabled  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A byte is taken whenever the queue is sure to have room for whatever
  // the byte now in the scanner and this one might produce. With an empty
  // or lightly used queue this never stalls, even while an event waits.
  assign rx_stall  = queue_full;
  assign rx_accept = rx_valid && !rx_stall;

  // The scanner registers the byte, compares it with the window of the
  // sixteen earlier bytes of the same buffer and then shifts it in.
  cfs_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_accept),
    .word    (rx_data),
    .gain_en (gain_handler_enabled),
    .arm_en  (arm_handler_enabled),
    .busy    (scan_busy),
    .push    (scan_push),
    .rec     (scan_rec)
  );

  // Each byte with at least one event becomes one queue record; a record with
  // both a gain and an arm event is sent as two words, gain first.
  cfs_event_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (scan_push),
    .rec       (scan_rec),
    .reserve   (scan_busy),
    .full      (queue_full),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data)
  );

endmodule

`default_nettype wire

/* src/cfs_scanner.sv */
// Input register, 16-byte sliding window and frame detection.
// Depends on cfs_pkg.
`default_nettype none

module cfs_scanner
  import cfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire frame_in_t word,
  input  wire logic      gain_en,
  input  wire logic      arm_en,
  output logic           busy,
  output logic           push,
  output hit_rec_t       rec
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_start;
  logic [7:0]       win [WIN_DEPTH];
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] valid_count_next;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       chk;
  logic             gain_ok;
  logic             arm_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_byte  <= word.rx_byte;
      s1_start <= word.buffer_start;
    end
  end

  // Entry 0 is the byte before the one in the input register.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        win[k] <= win[k-1];
      end
      win[0] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
    end else if (s1_valid) begin
      valid_count <= valid_count_next;
    end
  end

  always_comb begin
    cnt_eff          = s1_start ? '0 : valid_count;
    valid_count_next = (cnt_eff < WIN_FULL) ? cnt_eff + CNT_W'(1) : cnt_eff;

    chk = '0;
    for (int k = 1; k <= 14; k++) begin
      chk = chk ^ win[k];
    end

    // A gain frame ends on this byte when the oldest entry is its header.
    gain_ok = (cnt_eff >= GAIN_NEED) && (s1_byte == TAIL_BYTE) &&
              (win[15] == HDR_BYTE) && (win[14] == OP_GAIN) && (chk == win[0]);
    arm_frame = (cnt_eff >= ARM_NEED) && (s1_byte == TAIL_BYTE) &&
                (win[2] == HDR_BYTE);

    rec.gain_hit   = gain_ok && gain_en;
    rec.arm_hit    = arm_frame && arm_en &&
                     ((win[1] == OP_ARM) || (win[1] == OP_DISARM));
    rec.arm_kind   = (win[1] == OP_ARM) ? EVT_ARM : EVT_DISARM;
    rec.loop_index = win[13];
    rec.gain_p     = {win[9], win[10], win[11], win[12]};
    rec.gain_i     = {win[5], win[6], win[7], win[8]};
    rec.gain_d     = {win[1], win[2], win[3], win[4]};

    push = s1_valid && (rec.gain_hit || rec.arm_hit);
    busy = s1_valid;
  end

endmodule

`default_nettype wire

/* src/cfs_event_queue.sv */
// Event queue: holds per-byte hit records and sends them out one event a word.
// Depends on cfs_pkg.
`default_nettype none

module cfs_event_queue
  import cfs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire hit_rec_t   rec,
  input  wire logic       reserve,
  output logic            full,
  output logic            evt_valid,
  input  wire logic       evt_stall,
  output event_out_t      evt_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [QCNT_W:0]   DEPTH_W  = (QCNT_W + 1)'(DEPTH);

  hit_rec_t          q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              second;
  hit_rec_t          head;
  logic              head_last;
  logic              take;
  logic              pop;

  always_comb begin
    head      = q[rd_ptr];
    head_last = !(head.gain_hit && head.arm_hit) || second;
    evt_valid = (count != '0);
    take      = evt_valid && !evt_stall;
    pop       = take && head_last;
    // Room must exist for the byte in the scanner and the one about to enter.
    full      = ({1'b0, count} + (QCNT_W + 1)'(reserve)) >= DEPTH_W;

    if (head.gain_hit && !second) begin
      evt_data.event_kind  = EVT_GAIN;
      evt_data.loop_index  = head.loop_index;
      evt_data.gain_p_bits = head.gain_p;
      evt_data.gain_i_bits = head.gain_i;
      evt_data.gain_d_bits = head.gain_d;
      evt_data.last_event  = !head.arm_hit;
    end else begin
      evt_data.event_kind  = head.arm_kind;
      evt_data.loop_index  = '0;
      evt_data.gain_p_bits = '0;
      evt_data.gain_i_bits = '0;
      evt_data.gain_d_bits = '0;
      evt_data.last_event  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      second <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
      if (pop) begin
        second <= 1'b0;
      end else if (take) begin
        second <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= DEPTH_W)
    else $error("event queue count above depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> ({1'b0, count} < DEPTH_W) || pop)
    else $error("event queue overflow");

  a_second_needs_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> evt_valid && head.gain_hit && head.arm_hit)
    else $error("second event phase on a single-event record");

  a_head_has_event: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> head.gain_hit || head.arm_hit)
    else $error("queued record carries no event");
`endif

endmodule

`default_nettype wire
